// File: rtl/counting_pattern_checker_unit_macros.svh
// Assertion macros used by the counting pattern checker RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef COUNTING_PATTERN_CHECKER_UNIT_MACROS_SVH
`define COUNTING_PATTERN_CHECKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is high.
`define CPC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPC_ASSERT_RST(label, clk, rst, prop, msg)
`define CPC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/cpc_pkg.sv
// Types and constants of the counting pattern checker.
// No dependencies.
`default_nettype none

package cpc_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int COUNT_WIDTH  = 48;
   localparam int STATUS_WIDTH = 3;
   localparam int PRIME_LEN    = 3;

   typedef logic [BYTE_WIDTH-1:0]  byte_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam byte_type  HISTORY_RESET = '1;
   localparam count_type COUNT_MAX     = '1;

   typedef enum logic [1:0] {
      PH_PRIME = 2'd0,
      PH_SYNC  = 2'd1,
      PH_ERR   = 2'd2,
      PH_HALT  = 2'd3
   } phase_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_PRIMING   = 3'd0,
      ST_OK        = 3'd1,
      ST_SYNC_ERR  = 3'd2,
      ST_INSERTED  = 3'd3,
      ST_CORRUPTED = 3'd4,
      ST_MISSING   = 3'd5,
      ST_RESTARTED = 3'd6,
      ST_HALTED    = 3'd7
   } status_type;

   typedef struct packed {
      phase_type phase;
      byte_type  last;
      byte_type  second_last;
      count_type total;
   } state_type;

   typedef struct packed {
      status_type status;
      byte_type   detail;
      count_type  seen;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/cpc_ifs.sv
// Valid/ready channel interfaces of the counting pattern checker.
// Depends on cpc_pkg for field widths.
`default_nettype none

interface cpc_req_if;
   import cpc_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpc_rsp_if;
   import cpc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] check_status;
   byte_type                detail_byte;
   count_type               bytes_seen;
   modport source (output valid, output check_status, output detail_byte,
                   output bytes_seen, input ready);
   modport sink   (input valid, input check_status, input detail_byte,
                   input bytes_seen, output ready);
endinterface

interface cpc_csr_if;
   logic valid;
   logic ready;
   logic restart_on_loss;
   modport source (output valid, output restart_on_loss, input ready);
   modport sink   (input valid, input restart_on_loss, output ready);
endinterface

`default_nettype wire

// File: rtl/cpc_classify.sv
// Per-byte classification: next checker state and the result for one byte.
// Depends on cpc_pkg.
`default_nettype none

module cpc_classify (
   input  cpc_pkg::state_type  cur_state,
   input  cpc_pkg::byte_type   rx_byte,
   input  logic                restart_on_loss,
   output cpc_pkg::state_type  next_state,
   output cpc_pkg::result_type result
);
   import cpc_pkg::*;

   count_type total_inc;
   byte_type  p1_inc;
   byte_type  p1_dec;
   byte_type  p2_inc1;
   byte_type  p2_inc2;
   byte_type  p2_inc3;
   logic      primed;
   logic      check_sync;
   logic      mismatch;
   logic      is_inserted;
   logic      is_corrupted;
   logic      is_missing;
   phase_type next_phase;

   assign total_inc = (cur_state.total == COUNT_MAX) ? cur_state.total
                                                     : cur_state.total + COUNT_WIDTH'(1);
   assign p1_inc  = cur_state.last + BYTE_WIDTH'(1);
   assign p1_dec  = cur_state.last - BYTE_WIDTH'(1);
   assign p2_inc1 = cur_state.second_last + BYTE_WIDTH'(1);
   assign p2_inc2 = cur_state.second_last + BYTE_WIDTH'(2);
   assign p2_inc3 = cur_state.second_last + BYTE_WIDTH'(3);

   assign primed       = total_inc >= COUNT_WIDTH'(PRIME_LEN);
   assign check_sync   = (cur_state.phase == PH_SYNC) ||
                         ((cur_state.phase == PH_PRIME) && primed);
   assign mismatch     = rx_byte != p1_inc;
   assign is_inserted  = rx_byte == p2_inc1;
   assign is_corrupted = rx_byte == p2_inc2;
   assign is_missing   = !mismatch && (rx_byte == p2_inc3);

   // next phase
   always_comb begin
      case (cur_state.phase)
         PH_PRIME: begin
            if (!primed) begin
               next_phase = PH_PRIME;
            end else if (mismatch) begin
               next_phase = PH_ERR;
            end else begin
               next_phase = PH_SYNC;
            end
         end
         PH_SYNC: begin
            next_phase = mismatch ? PH_ERR : PH_SYNC;
         end
         PH_ERR: begin
            if (is_inserted || is_corrupted || is_missing) begin
               next_phase = PH_SYNC;
            end else if (restart_on_loss) begin
               next_phase = PH_PRIME;
            end else begin
               next_phase = PH_HALT;
            end
         end
         default: begin
            next_phase = PH_HALT;
         end
      endcase
   end

   // result and data part of the next state
   always_comb begin
      result.status          = ST_PRIMING;
      result.detail          = rx_byte;
      result.seen            = total_inc;
      next_state.phase       = next_phase;
      next_state.last        = rx_byte;
      next_state.second_last = cur_state.last;
      next_state.total       = total_inc;
      if (cur_state.phase == PH_HALT) begin
         // frozen: report the byte, keep everything
         result.status          = ST_HALTED;
         result.seen            = cur_state.total;
         next_state.last        = cur_state.last;
         next_state.second_last = cur_state.second_last;
         next_state.total       = cur_state.total;
      end else if (check_sync) begin
         if (mismatch) begin
            result.status = ST_SYNC_ERR;
            result.detail = p1_inc;
         end else begin
            result.status = ST_OK;
         end
      end else if (cur_state.phase == PH_ERR) begin
         if (is_inserted) begin
            result.status = ST_INSERTED;
            result.detail = cur_state.last;
         end else if (is_corrupted) begin
            result.status = ST_CORRUPTED;
            result.detail = cur_state.last;
         end else if (is_missing) begin
            result.status = ST_MISSING;
            result.detail = p1_dec;
         end else if (restart_on_loss) begin
            result.status    = ST_RESTARTED;
            result.seen      = '0;
            next_state.total = '0;
         end else begin
            result.status = ST_HALTED;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/counting_pattern_checker_unit.sv
// Top level of the counting pattern checker: input register, classifier, result register.
// Depends on cpc_pkg, cpc_ifs, cpc_classify and the assertion macro header.
`default_nettype none
`include "counting_pattern_checker_unit_macros.svh"

// Checks a received byte stream against an incrementing modulo-256 pattern and
// returns exactly one result per byte transfer: a status code, a detail byte and
// the saturating 48-bit byte count. The first bytes only prime the history; from
// the third byte on, a byte that is not the previous byte plus one reports a sync
// error, and the following byte classifies it as inserted, corrupted or missing,
// or as lost. A lost sync restarts priming (count zeroed) when restart_on_loss is
// set, or halts the checker until reset when it is clear; a halted checker keeps
// answering with status halted and the frozen count. Throughput is one byte per
// clock while the rsp side is ready; a byte passes from its req transfer into the
// input register, then through the compare logic and the 48-bit count increment
// into the result register, which drives the rsp channel. Both registers keep moving
// while the rsp side stalls until both are full. Write restart_on_loss over the
// csr channel (always ready) only while no byte is in flight; reset clears it.
module counting_pattern_checker_unit (
   input  logic  clock,
   input  logic  reset,
   cpc_req_if.sink   req_if,
   cpc_rsp_if.source rsp_if,
   cpc_csr_if.sink   csr_if
);
   import cpc_pkg::*;

   // configuration
   logic restart_ff;
   logic restart_in;

   // input register
   logic     in_valid_ff;
   logic     in_valid_in;
   byte_type in_byte_ff;
   byte_type in_byte_in;

   // checker state
   state_type state_ff;
   state_type state_in;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;

   state_type  cls_state;
   result_type cls_result;
   logic       advance;
   logic       req_xfer;

   // move the held byte forward when the result register is free or drains now
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_xfer = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   cpc_classify u_classify (
      .cur_state       (state_ff),
      .rx_byte         (in_byte_ff),
      .restart_on_loss (restart_ff),
      .next_state      (cls_state),
      .result          (cls_result)
   );

   always_comb begin
      restart_in   = csr_if.valid ? csr_if.restart_on_loss : restart_ff;
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      in_byte_in   = req_xfer ? req_if.rx_byte : in_byte_ff;
      // state advances with each byte that leaves the input register
      state_in     = advance ? cls_state : state_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
      result_in    = advance ? cls_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff           <= 1'b0;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.phase       <= PH_PRIME;
         state_ff.last        <= HISTORY_RESET;
         state_ff.second_last <= HISTORY_RESET;
         state_ff.total       <= '0;
      end else begin
         restart_ff   <= restart_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.check_status = result_ff.status;
   assign rsp_if.detail_byte  = result_ff.detail;
   assign rsp_if.bytes_seen   = result_ff.seen;

   `CPC_ASSERT_RST(a_halt_sticky, clock, reset, state_ff.phase == PH_HALT |=> state_ff.phase == PH_HALT, "halted checker left halt")
   `CPC_ASSERT_RST(a_restart_zero, clock, reset, rsp_if.valid && rsp_if.check_status == ST_RESTARTED |-> rsp_if.bytes_seen == '0, "restart result with nonzero count")
   `CPC_ASSERT_RST(a_in_hold, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff), "held input byte lost or changed")
   `CPC_ASSERT_RST(a_count_mono, clock, reset, advance && cls_result.status != ST_RESTARTED |=> state_ff.total >= $past(state_ff.total), "byte count went backward")
   `CPC_ASSERT_RST(a_sync_err_src, clock, reset, advance && cls_result.status == ST_SYNC_ERR |-> state_ff.phase == PH_SYNC || state_ff.phase == PH_PRIME, "sync error outside checking phase")

endmodule

`default_nettype wire
